// ----- rtl/core/nnis_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared types, sizes and codes for the nearest-neighbor image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

	// Frame and pixel sizes.
	localparam int MAX_DIM     = 256;
	localparam int MAX_OUT_DIM = 1024;
	localparam int PIXEL_BITS  = 32;

	// Field and register widths.
	localparam int COORD_W   = 10;
	localparam int SRC_SZ_W  = 9;
	localparam int DST_SZ_W  = 11;
	localparam int CFG_IDX_W = 2;
	localparam int SRC_IDX_W = $clog2(MAX_DIM);
	localparam int ADDR_W    = 2 * SRC_IDX_W;
	localparam int PROD_W    = COORD_W + SRC_SZ_W;

	// One quotient bit per divider step; the quotient stays below MAX_DIM.
	localparam int DIV_STEPS = SRC_IDX_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// Stream payload layout.
	localparam int IN_FIELDS_W = 2 * COORD_W + PIXEL_BITS;
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((PIXEL_BITS + 7) / 8) * 8;

	// Command codes carried on s_tuser.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

	// Reset value of every size register.
	localparam int SIZE_RESET = 256;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_MEM,
		ST_OUT
	} nnis_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic store_wr;
		logic accept_rd;
		logic mul_en;
		logic div_en;
		logic mem_rd;
		logic out_load;
	} nnis_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic rd_err;
		logic div_last;
		logic out_free;
	} nnis_status_t;

	// A source size of zero counts as one, and anything above MAX_DIM as MAX_DIM.
	function automatic logic [SRC_SZ_W-1:0] clamp_src(input logic [SRC_SZ_W-1:0] v);
		logic [SRC_SZ_W-1:0] r;
		if (v == '0) begin
			r = SRC_SZ_W'(1);
		end else if (v > SRC_SZ_W'(MAX_DIM)) begin
			r = SRC_SZ_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Same for destination sizes against MAX_OUT_DIM.
	function automatic logic [DST_SZ_W-1:0] clamp_dst(input logic [DST_SZ_W-1:0] v);
		logic [DST_SZ_W-1:0] r;
		if (v == '0) begin
			r = DST_SZ_W'(1);
		end else if (v > DST_SZ_W'(MAX_OUT_DIM)) begin
			r = DST_SZ_W'(MAX_OUT_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/nnis_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nnis_ctrl
// Sequencer for the scaler: takes items, steps an in-range read through
// multiply, divide, frame store read and result load.
// ----------------------------------------------------------------------------
module nnis_ctrl (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	input  wire logic                    s_cmd,
	input  wire nnis_pkg::nnis_status_t  status,
	output logic                         s_tready,
	output nnis_pkg::nnis_cmd_t          cmd
);
	import nnis_pkg::*;

	nnis_state_t state_q;
	nnis_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_cmd == CMD_READ) begin
						cmd.accept_rd = 1'b1;
						state_d = status.rd_err ? ST_OUT : ST_MUL;
					end else begin
						cmd.store_wr = 1'b1;
					end
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_en = 1'b1;
				if (status.div_last) begin
					state_d = ST_MEM;
				end
			end
			ST_MEM: begin
				cmd.mem_rd = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/core/nnis_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nnis_datapath
// Size registers, coordinate scaling with a shared-step restoring divider,
// the source frame store and the result register.
// ----------------------------------------------------------------------------
module nnis_datapath (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [nnis_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [nnis_pkg::DST_SZ_W-1:0]          cfg_data,
	input  wire logic [nnis_pkg::IN_TDATA_W-1:0]        s_tdata,
	input  wire logic                                   m_tready,
	input  wire nnis_pkg::nnis_cmd_t                    cmd,
	output nnis_pkg::nnis_status_t                      status,
	output logic                                        m_tvalid,
	output logic [nnis_pkg::OUT_TDATA_W-1:0]            m_tdata,
	output logic                                        m_tuser
);
	import nnis_pkg::*;

	logic [SRC_SZ_W-1:0]   src_width_q;
	logic [SRC_SZ_W-1:0]   src_height_q;
	logic [DST_SZ_W-1:0]   dst_width_q;
	logic [DST_SZ_W-1:0]   dst_height_q;
	logic [SRC_SZ_W-1:0]   sw;
	logic [SRC_SZ_W-1:0]   sh;
	logic [DST_SZ_W-1:0]   dw;
	logic [DST_SZ_W-1:0]   dh;
	logic [COORD_W-1:0]    in_x;
	logic [COORD_W-1:0]    in_y;
	logic [PIXEL_BITS-1:0] in_pixel;
	logic [COORD_W-1:0]    x_q;
	logic [COORD_W-1:0]    y_q;
	logic                  err_q;
	logic [PROD_W-1:0]     rem_x_q;
	logic [PROD_W-1:0]     rem_y_q;
	logic [SRC_IDX_W-1:0]  qx_q;
	logic [SRC_IDX_W-1:0]  qy_q;
	logic [STEP_W-1:0]     step_q;
	logic [PROD_W-1:0]     div_x_sh;
	logic [PROD_W-1:0]     div_y_sh;
	logic                  fit_x;
	logic                  fit_y;
	logic [PIXEL_BITS-1:0] rd_data_q;
	logic                  m_tvalid_q;
	logic [PIXEL_BITS-1:0] m_pixel_q;
	logic                  m_err_q;
	logic [PIXEL_BITS-1:0] frame_mem [2**ADDR_W];

	// Input item fields.
	assign in_x     = s_tdata[COORD_W-1:0];
	assign in_y     = s_tdata[2*COORD_W-1:COORD_W];
	assign in_pixel = s_tdata[2*COORD_W+PIXEL_BITS-1:2*COORD_W];

	// Size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SRC_SZ_W'(SIZE_RESET);
			src_height_q <= SRC_SZ_W'(SIZE_RESET);
			dst_width_q  <= DST_SZ_W'(SIZE_RESET);
			dst_height_q <= DST_SZ_W'(SIZE_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_WIDTH:  src_width_q  <= cfg_data[SRC_SZ_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= cfg_data[SRC_SZ_W-1:0];
				REG_DST_WIDTH:  dst_width_q  <= cfg_data;
				REG_DST_HEIGHT: dst_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign sw = clamp_src(src_width_q);
	assign sh = clamp_src(src_height_q);
	assign dw = clamp_dst(dst_width_q);
	assign dh = clamp_dst(dst_height_q);

	// A read outside the destination frame is flagged at once.
	assign status.rd_err = (COORD_W+1)'(in_x) >= (COORD_W+1)'(dw)
		|| (COORD_W+1)'(in_y) >= (COORD_W+1)'(dh);

	// Divisor shifted to the weight of the current quotient bit.
	assign div_x_sh = PROD_W'(dw) << step_q;
	assign div_y_sh = PROD_W'(dh) << step_q;
	assign fit_x    = rem_x_q >= div_x_sh;
	assign fit_y    = rem_y_q >= div_y_sh;

	assign status.div_last = step_q == '0;

	// Coordinate capture, products and one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (cmd.accept_rd) begin
			x_q   <= in_x;
			y_q   <= in_y;
			err_q <= status.rd_err;
		end
		if (cmd.mul_en) begin
			rem_x_q <= PROD_W'(x_q) * PROD_W'(sw);
			rem_y_q <= PROD_W'(y_q) * PROD_W'(sh);
			step_q  <= STEP_W'(DIV_STEPS - 1);
		end else if (cmd.div_en) begin
			if (fit_x) begin
				rem_x_q <= rem_x_q - div_x_sh;
			end
			if (fit_y) begin
				rem_y_q <= rem_y_q - div_y_sh;
			end
			qx_q   <= {qx_q[SRC_IDX_W-2:0], fit_x};
			qy_q   <= {qy_q[SRC_IDX_W-2:0], fit_y};
			step_q <= step_q - STEP_W'(1);
		end
	end

	// Source frame store: row-major, MAX_DIM words per row.
	always_ff @(posedge clk) begin
		if (cmd.store_wr && (COORD_W+1)'(in_x) < (COORD_W+1)'(sw)
				&& (COORD_W+1)'(in_y) < (COORD_W+1)'(sh)) begin
			frame_mem[{in_y[SRC_IDX_W-1:0], in_x[SRC_IDX_W-1:0]}] <= in_pixel;
		end
		if (cmd.mem_rd) begin
			rd_data_q <= frame_mem[{qy_q, qx_q}];
		end
	end

	// Result register; it frees up in the same cycle that the item is taken.
	assign status.out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_pixel_q <= err_q ? '0 : rd_data_q;
			m_err_q   <= err_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_W'(m_pixel_q);
	assign m_tuser  = m_err_q;

endmodule
`default_nettype wire

// ----- rtl/core/nearest_neighbor_image_scaler.sv -----
// A write item gives no result; writes stream at one per cycle while no read is in flight.
// A read in range steps through multiply, the 8-step divider with one quotient bit per
// cycle, the frame store read and the result load, which waits for a free result register.
// A read outside the destination goes from acceptance straight to the result load.
// Reset clears the size registers to 256 and all handshake state at once; the frame store
// is not cleared, and no item is held off after reset.
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler
// Stores a source frame by pixel writes and returns, for a destination
// coordinate, the nearest source pixel after integer scaling.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Configuration write port.
	input  wire logic                               cfg_we,
	input  wire logic [nnis_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [nnis_pkg::DST_SZ_W-1:0]      cfg_data,
	// Input items.
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// coord_x [9:0], coord_y [19:10], pixel_in [51:20], zero fill [55:52]
	input  wire logic [nnis_pkg::IN_TDATA_W-1:0]    s_tdata,
	// cmd [0]
	input  wire logic                               s_tuser,
	// Result items.
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// pixel_out [31:0]
	output logic [nnis_pkg::OUT_TDATA_W-1:0]        m_tdata,
	// range_error [0]
	output logic                                    m_tuser
);
	import nnis_pkg::*;

	nnis_cmd_t    cmd;
	nnis_status_t status;

	nnis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_cmd    (s_tuser),
		.status   (status),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	nnis_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.cmd       (cmd),
		.status    (status),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// A flagged read always carries a zero pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("range error result with nonzero pixel");

	// The result register is only loaded when it is empty or being drained.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("result overwritten before it was taken");

	// An in-range read never produces its result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == CMD_READ && !status.rd_err |=> !cmd.out_load)
		else $error("in-range read skipped the scaling steps");

	// Nothing is accepted while a read is in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_en || cmd.mem_rd || cmd.mul_en |-> !s_tready)
		else $error("item accepted during a read");

endmodule
`default_nettype wire
